// File: hdl/csvti_pkg.sv
package csvti_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_BYTE       = 2'd0,
    CMD_EMPTY      = 2'd1,
    CMD_NEW_COLUMN = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    TYPE_CHARACTER = 2'd0,
    TYPE_LOGICAL   = 2'd1,
    TYPE_INTEGER   = 2'd2,
    TYPE_DOUBLE    = 2'd3
  } col_type_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_SIGN,
    PH_INT,
    PH_DOT0,
    PH_FRAC,
    PH_EXP,
    PH_EXPSIGN,
    PH_EXPDIG,
    PH_BAD
  } phase_t;

  // bit positions of the spelling candidates
  localparam int unsigned WM_TRUE_U  = 0;
  localparam int unsigned WM_TRUE_L  = 1;
  localparam int unsigned WM_FALSE_U = 2;
  localparam int unsigned WM_FALSE_L = 3;
  localparam int unsigned WM_INF     = 4;
  localparam int unsigned WM_NAN     = 5;

  // words sit right-aligned, first letter highest
  localparam logic [63:0] WORD_TRUE_U  = "TRUE";
  localparam logic [63:0] WORD_TRUE_L  = "true";
  localparam logic [63:0] WORD_FALSE_U = "FALSE";
  localparam logic [63:0] WORD_FALSE_L = "false";
  localparam logic [63:0] WORD_INF     = "Inf";
  localparam logic [63:0] WORD_NAN     = "NaN";
  localparam logic [2:0]  LEN_TRUE     = 3'd4;
  localparam logic [2:0]  LEN_FALSE    = 3'd5;
  localparam logic [2:0]  LEN_SPECIAL  = 3'd3;

  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_E_UP  = "E";
  localparam logic [7:0] CH_E_LO  = "e";

  localparam logic [2:0] POS_MAX = 3'd6;

  localparam logic signed [35:0] INT_MAX_WIDE = 36'sd2147483647;
  localparam logic signed [35:0] INT_MIN_WIDE = -36'sd2147483647;

  // classified item handed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       last;
    logic       is_digit;
    logic       is_sign;
    logic       is_minus;
    logic       is_dot;
    logic       is_exp;
    logic [3:0] digit;
  } item_t;

  // letter of word w at position p equals b
  function automatic logic word_hit(logic [63:0] w, logic [2:0] len, logic [2:0] p,
                                    logic [7:0] b);
    logic [2:0] rev;
    logic [5:0] base;
    rev  = len - 3'd1 - p;
    base = {rev, 3'b000};
    return (p < len) && (w[base +: 8] == b);
  endfunction

endpackage

// File: hdl/csvti_front.sv
module csvti_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [7:0]         data_byte,
  input  logic               cell_last,
  output logic               item_valid,
  input  logic               item_ready,
  output csvti_pkg::item_t   item
);

  csvti_pkg::item_t item_class;

  always_comb begin
    item_class.cmd      = csvti_pkg::cmd_t'(cmd);
    item_class.data     = data_byte;
    item_class.last     = cell_last;
    item_class.is_digit = (data_byte >= csvti_pkg::CH_ZERO) && (data_byte <= csvti_pkg::CH_NINE);
    item_class.is_minus = (data_byte == csvti_pkg::CH_MINUS);
    item_class.is_sign  = (data_byte == csvti_pkg::CH_PLUS) || item_class.is_minus;
    item_class.is_dot   = (data_byte == csvti_pkg::CH_DOT);
    item_class.is_exp   = (data_byte == csvti_pkg::CH_E_UP) ||
                          (data_byte == csvti_pkg::CH_E_LO);
    item_class.digit    = data_byte[3:0];
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_class;
    end
  end

endmodule

// File: hdl/csvti_queue.sv
module csvti_queue #(
  parameter int unsigned DEPTH = csvti_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  csvti_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output csvti_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  csvti_pkg::item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hdl/csvti_back.sv
module csvti_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  csvti_pkg::item_t        item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              column_type,
  output logic                    from_cell,
  output logic                    cell_is_logical,
  output logic                    cell_logical_value,
  output logic                    cell_is_integer,
  output logic signed [31:0]      cell_int_value,
  output logic                    cell_is_double
);

  // column state
  logic may_logical, may_logical_next;
  logic may_integer, may_integer_next;
  logic may_double, may_double_next;
  logic no_cell_seen, no_cell_seen_next;
  // cell state
  logic [2:0]          byte_pos, byte_pos_next;
  logic [5:0]          word_flags, word_flags_next;
  logic signed [31:0]  int_acc, int_acc_next;
  logic                int_sign, int_sign_next;
  logic                int_neg, int_neg_next;
  logic                int_ovf, int_ovf_next;
  csvti_pkg::phase_t   phase, phase_next, phase_byte;

  // result
  logic                   out_valid_next;
  logic                   res_load;
  csvti_pkg::col_type_t   res_type;
  logic                   res_from_cell, res_lg, res_lv, res_ig, res_db;
  logic signed [31:0]     res_iv;

  // per-byte datapath
  logic                   take;
  logic [2:0]             p;
  logic                   lead_sign;
  logic [5:0]             wm;
  logic                   sign_b, neg_b, ovf_b, acc_upd, over;
  logic signed [35:0]     acc_ext, acc_wide, digit_ext;
  logic signed [31:0]     acc_b;
  logic [2:0]             pos_b;
  logic                   lg, lv, ig, db;
  logic                   ml_fin, mi_fin, md_fin;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  function automatic csvti_pkg::col_type_t col_type(logic none, logic ml, logic mi, logic md);
    csvti_pkg::col_type_t t;
    priority if (none) t = csvti_pkg::TYPE_CHARACTER;
    else if (ml)       t = csvti_pkg::TYPE_LOGICAL;
    else if (mi)       t = csvti_pkg::TYPE_INTEGER;
    else if (md)       t = csvti_pkg::TYPE_DOUBLE;
    else               t = csvti_pkg::TYPE_CHARACTER;
    return t;
  endfunction

  // number grammar phase for a byte
  always_comb begin
    unique case (phase)
      csvti_pkg::PH_START: begin
        priority if (item.is_sign) phase_byte = csvti_pkg::PH_SIGN;
        else if (item.is_digit)    phase_byte = csvti_pkg::PH_INT;
        else if (item.is_dot)      phase_byte = csvti_pkg::PH_DOT0;
        else                       phase_byte = csvti_pkg::PH_BAD;
      end
      csvti_pkg::PH_SIGN: begin
        priority if (item.is_digit) phase_byte = csvti_pkg::PH_INT;
        else if (item.is_dot)       phase_byte = csvti_pkg::PH_DOT0;
        else                        phase_byte = csvti_pkg::PH_BAD;
      end
      csvti_pkg::PH_INT: begin
        priority if (item.is_digit) phase_byte = csvti_pkg::PH_INT;
        else if (item.is_dot)       phase_byte = csvti_pkg::PH_FRAC;
        else if (item.is_exp)       phase_byte = csvti_pkg::PH_EXP;
        else                        phase_byte = csvti_pkg::PH_BAD;
      end
      csvti_pkg::PH_DOT0: begin
        phase_byte = item.is_digit ? csvti_pkg::PH_FRAC : csvti_pkg::PH_BAD;
      end
      csvti_pkg::PH_FRAC: begin
        priority if (item.is_digit) phase_byte = csvti_pkg::PH_FRAC;
        else if (item.is_exp)       phase_byte = csvti_pkg::PH_EXP;
        else                        phase_byte = csvti_pkg::PH_BAD;
      end
      csvti_pkg::PH_EXP: begin
        priority if (item.is_sign) phase_byte = csvti_pkg::PH_EXPSIGN;
        else if (item.is_digit)    phase_byte = csvti_pkg::PH_EXPDIG;
        else                       phase_byte = csvti_pkg::PH_BAD;
      end
      csvti_pkg::PH_EXPSIGN, csvti_pkg::PH_EXPDIG: begin
        phase_byte = item.is_digit ? csvti_pkg::PH_EXPDIG : csvti_pkg::PH_BAD;
      end
      default: phase_byte = csvti_pkg::PH_BAD;
    endcase
  end

  // next state of the grammar
  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (item.cmd)
        csvti_pkg::CMD_BYTE:       phase_next = item.last ? csvti_pkg::PH_START : phase_byte;
        csvti_pkg::CMD_EMPTY,
        csvti_pkg::CMD_NEW_COLUMN: phase_next = csvti_pkg::PH_START;
        csvti_pkg::CMD_QUERY:      phase_next = phase;
        default:                   phase_next = phase;
      endcase
    end
  end

  // byte datapath, column flags and result
  always_comb begin
    p         = byte_pos;
    lead_sign = (p == 3'd0) && item.is_sign;

    wm = word_flags;
    if (!csvti_pkg::word_hit(csvti_pkg::WORD_TRUE_U, csvti_pkg::LEN_TRUE, p, item.data))
      wm[csvti_pkg::WM_TRUE_U] = 1'b0;
    if (!csvti_pkg::word_hit(csvti_pkg::WORD_TRUE_L, csvti_pkg::LEN_TRUE, p, item.data))
      wm[csvti_pkg::WM_TRUE_L] = 1'b0;
    if (!csvti_pkg::word_hit(csvti_pkg::WORD_FALSE_U, csvti_pkg::LEN_FALSE, p, item.data))
      wm[csvti_pkg::WM_FALSE_U] = 1'b0;
    if (!csvti_pkg::word_hit(csvti_pkg::WORD_FALSE_L, csvti_pkg::LEN_FALSE, p, item.data))
      wm[csvti_pkg::WM_FALSE_L] = 1'b0;
    if (lead_sign) begin
      wm[csvti_pkg::WM_NAN] = 1'b0;
    end else begin
      // Inf is counted after an optional leading sign
      if ((p < {2'b00, int_sign}) ||
          !csvti_pkg::word_hit(csvti_pkg::WORD_INF, csvti_pkg::LEN_SPECIAL,
                               p - {2'b00, int_sign}, item.data))
        wm[csvti_pkg::WM_INF] = 1'b0;
      if (!csvti_pkg::word_hit(csvti_pkg::WORD_NAN, csvti_pkg::LEN_SPECIAL, p, item.data))
        wm[csvti_pkg::WM_NAN] = 1'b0;
    end

    sign_b = int_sign | lead_sign;
    neg_b  = int_neg | (lead_sign & item.is_minus);

    // accumulate with the sign already applied, times ten as two shifts
    acc_ext   = {{4{int_acc[31]}}, int_acc};
    digit_ext = {32'd0, item.digit};
    acc_wide  = int_neg ? (acc_ext <<< 3) + (acc_ext <<< 1) - digit_ext
                        : (acc_ext <<< 3) + (acc_ext <<< 1) + digit_ext;
    over      = int_neg ? (acc_wide < csvti_pkg::INT_MIN_WIDE)
                        : (acc_wide > csvti_pkg::INT_MAX_WIDE);
    acc_upd   = !lead_sign && item.is_digit && !int_ovf;
    ovf_b     = int_ovf | (acc_upd & over);
    acc_b     = (acc_upd && !over) ? acc_wide[31:0] : int_acc;
    pos_b     = (p == csvti_pkg::POS_MAX) ? p : p + 3'd1;

    // cell verdict when this byte ends the cell
    lv = (wm[csvti_pkg::WM_TRUE_U] | wm[csvti_pkg::WM_TRUE_L]) && (pos_b == csvti_pkg::LEN_TRUE);
    lg = lv || ((wm[csvti_pkg::WM_FALSE_U] | wm[csvti_pkg::WM_FALSE_L]) &&
                (pos_b == csvti_pkg::LEN_FALSE));
    ig = (phase_byte == csvti_pkg::PH_INT) && !ovf_b;
    db = (phase_byte == csvti_pkg::PH_INT) || (phase_byte == csvti_pkg::PH_FRAC) ||
         (phase_byte == csvti_pkg::PH_EXPDIG) ||
         (wm[csvti_pkg::WM_INF] && (pos_b == csvti_pkg::LEN_SPECIAL + {2'b00, sign_b})) ||
         (wm[csvti_pkg::WM_NAN] && (pos_b == csvti_pkg::LEN_SPECIAL));
    ml_fin = may_logical & lg;
    mi_fin = may_integer & ig;
    md_fin = may_double & db;

    may_logical_next  = may_logical;
    may_integer_next  = may_integer;
    may_double_next   = may_double;
    no_cell_seen_next = no_cell_seen;
    byte_pos_next     = byte_pos;
    word_flags_next   = word_flags;
    int_acc_next      = int_acc;
    int_sign_next     = int_sign;
    int_neg_next      = int_neg;
    int_ovf_next      = int_ovf;

    res_load      = 1'b0;
    res_type      = col_type(no_cell_seen, may_logical, may_integer, may_double);
    res_from_cell = 1'b0;
    res_lg        = 1'b0;
    res_lv        = 1'b0;
    res_ig        = 1'b0;
    res_iv        = '0;
    res_db        = 1'b0;

    if (take) begin
      unique case (item.cmd)
        csvti_pkg::CMD_BYTE: begin
          if (item.last) begin
            may_logical_next  = ml_fin;
            may_integer_next  = mi_fin;
            may_double_next   = md_fin;
            no_cell_seen_next = 1'b0;
            byte_pos_next     = '0;
            word_flags_next   = '1;
            int_acc_next      = '0;
            int_sign_next     = 1'b0;
            int_neg_next      = 1'b0;
            int_ovf_next      = 1'b0;
            res_load          = 1'b1;
            res_type          = col_type(1'b0, ml_fin, mi_fin, md_fin);
            res_from_cell     = 1'b1;
            res_lg            = lg;
            res_lv            = lv;
            res_ig            = ig;
            res_iv            = ig ? acc_b : '0;
            res_db            = db;
          end else begin
            byte_pos_next   = pos_b;
            word_flags_next = wm;
            int_acc_next    = acc_b;
            int_sign_next   = sign_b;
            int_neg_next    = neg_b;
            int_ovf_next    = ovf_b;
          end
        end
        csvti_pkg::CMD_EMPTY: begin
          may_logical_next  = 1'b0;
          may_integer_next  = 1'b0;
          may_double_next   = 1'b0;
          no_cell_seen_next = 1'b0;
          byte_pos_next     = '0;
          word_flags_next   = '1;
          int_acc_next      = '0;
          int_sign_next     = 1'b0;
          int_neg_next      = 1'b0;
          int_ovf_next      = 1'b0;
          res_load          = 1'b1;
          res_type          = csvti_pkg::TYPE_CHARACTER;
          res_from_cell     = 1'b1;
        end
        csvti_pkg::CMD_NEW_COLUMN: begin
          may_logical_next  = 1'b1;
          may_integer_next  = 1'b1;
          may_double_next   = 1'b1;
          no_cell_seen_next = 1'b1;
          byte_pos_next     = '0;
          word_flags_next   = '1;
          int_acc_next      = '0;
          int_sign_next     = 1'b0;
          int_neg_next      = 1'b0;
          int_ovf_next      = 1'b0;
        end
        csvti_pkg::CMD_QUERY: begin
          res_load = 1'b1;
        end
        default: begin
          res_load = 1'b0;
        end
      endcase
    end

    out_valid_next = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      may_logical  <= 1'b1;
      may_integer  <= 1'b1;
      may_double   <= 1'b1;
      no_cell_seen <= 1'b1;
      byte_pos     <= '0;
      word_flags   <= '1;
      int_acc      <= '0;
      int_sign     <= 1'b0;
      int_neg      <= 1'b0;
      int_ovf      <= 1'b0;
      phase        <= csvti_pkg::PH_START;
      out_valid    <= 1'b0;
    end else begin
      may_logical  <= may_logical_next;
      may_integer  <= may_integer_next;
      may_double   <= may_double_next;
      no_cell_seen <= no_cell_seen_next;
      byte_pos     <= byte_pos_next;
      word_flags   <= word_flags_next;
      int_acc      <= int_acc_next;
      int_sign     <= int_sign_next;
      int_neg      <= int_neg_next;
      int_ovf      <= int_ovf_next;
      phase        <= phase_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      column_type        <= res_type;
      from_cell          <= res_from_cell;
      cell_is_logical    <= res_lg;
      cell_logical_value <= res_lv;
      cell_is_integer    <= res_ig;
      cell_int_value     <= res_iv;
      cell_is_double     <= res_db;
    end
  end

endmodule

// File: hdl/csv_column_type_inference.sv
// csv column type inference: cell text arrives one byte per transfer (cmd 0, cell_last on
// the final byte), cmd 1 marks an empty non-missing cell, cmd 2 starts a new column and
// cmd 3 asks for the current column type. every finished cell gives one result transfer
// with the cell's logical / integer / double verdict, its integer value and the column
// type after that cell; a query gives the column type with from_cell low and all cell
// fields zero; a new-column command and cell bytes other than the last give no result.
// the block takes one transfer per cycle while the output side is not stalled; that rate
// is set by the back end's per-byte update, a times-ten accumulate and range compare on a
// signed 36-bit value. a transfer passes the front register, the queue and the output
// register and waits behind earlier items in the queue. the queue of QUEUE_DEPTH entries
// lets the input side keep going while the output side is stalled, until the queue fills.
module csv_column_type_inference #(
  parameter int unsigned QUEUE_DEPTH = csvti_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [7:0]         data_byte,
  input  logic               cell_last,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         column_type,
  output logic               from_cell,
  output logic               cell_is_logical,
  output logic               cell_logical_value,
  output logic               cell_is_integer,
  output logic signed [31:0] cell_int_value,
  output logic               cell_is_double
);

  // front to queue
  csvti_pkg::item_t front_item;
  logic             front_valid;
  logic             front_ready;
  // queue to back
  csvti_pkg::item_t back_item;
  logic             back_valid;
  logic             back_ready;

  // front: registers the transfer and decodes the byte class
  csvti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .cell_last  (cell_last),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  // decoupling queue so the front keeps accepting while results wait
  csvti_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  // back: per-cell matching, integer accumulate, column flags, output register
  csvti_back u_back (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (back_valid),
    .item_ready         (back_ready),
    .item               (back_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .column_type        (column_type),
    .from_cell          (from_cell),
    .cell_is_logical    (cell_is_logical),
    .cell_logical_value (cell_logical_value),
    .cell_is_integer    (cell_is_integer),
    .cell_int_value     (cell_int_value),
    .cell_is_double     (cell_is_double)
  );

endmodule

// File: hdl/csvti_checker.sv
module csvti_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         column_type,
  input logic               from_cell,
  input logic               cell_is_logical,
  input logic               cell_logical_value,
  input logic               cell_is_integer,
  input logic signed [31:0] cell_int_value,
  input logic               cell_is_double
);

  // nothing pending right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(column_type) && $stable(from_cell) &&
                                $stable(cell_int_value) && $stable(cell_is_double))
    else $error("stalled result changed");

  // a query answer carries no cell verdict
  a_query_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !from_cell |-> !cell_is_logical && !cell_logical_value &&
                                !cell_is_integer && !cell_is_double && (cell_int_value == 0))
    else $error("query answer carries cell fields");

  // integer value only with an integer verdict, logical value only with a logical verdict
  a_int_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!cell_is_integer || cell_logical_value) |-> (cell_int_value == 0) &&
                                                             (cell_is_logical ||
                                                              !cell_logical_value))
    else $error("integer value or logical value without matching verdict");

  // a cell that is not a double clears both numeric flags of the column
  a_non_double_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && from_cell && !cell_is_double |->
      (column_type == csvti_pkg::TYPE_CHARACTER) || (column_type == csvti_pkg::TYPE_LOGICAL))
    else $error("numeric column type after a non-numeric cell");

endmodule

bind csv_column_type_inference csvti_checker u_checker (.*);
